// ===== rtl/pid_lqr_motor_angle_step_core_defines.svh =====
// Assertion macros for the motor angle step controller.
`ifndef PID_LQR_MOTOR_ANGLE_STEP_CORE_DEFINES_SVH
`define PID_LQR_MOTOR_ANGLE_STEP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PLQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define PLQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define PLQ_ASSERT_IMP(lbl, ante, cons)
`define PLQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/pidlqr_pkg.sv =====
// Shared constants and types for the motor angle step controller.
package pidlqr_pkg;

  localparam int unsigned DataW    = 16;
  localparam int unsigned VelW     = 17;
  localparam int unsigned SumW     = 48;
  localparam int unsigned AccW     = 64;
  localparam int unsigned UW       = 40;
  localparam int unsigned IntW     = 34;
  localparam int unsigned DivW     = 33;
  localparam int unsigned MulSteps = 16;
  localparam int unsigned MulCntW  = $clog2(MulSteps);
  localparam int unsigned DivCntW  = $clog2(DivW);
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [DataW-1:0] MinDt = 16'd7;

  // Register reset values
  localparam logic [DataW-1:0] KpRst     = 16'd13107;
  localparam logic [DataW-1:0] KiRst     = 16'd492;
  localparam logic [DataW-1:0] KdRst     = 16'd1638;
  localparam logic [DataW-1:0] KfbRst    = 16'd11993;
  localparam logic [DataW-1:0] TargetRst = 16'd5376;
  localparam logic [DataW-1:0] MaxVelRst = 16'd768;
  localparam logic [DataW-1:0] AngMinRst = 16'd2560;
  localparam logic [DataW-1:0] AngMaxRst = 16'd43520;
  localparam logic [DataW-1:0] AngleRst  = 16'd11520;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};
  localparam logic signed [34:0]     StepRound = 35'sd32768;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t RegKp     = 3'd0;
  localparam cfg_idx_t RegKi     = 3'd1;
  localparam cfg_idx_t RegKd     = 3'd2;
  localparam cfg_idx_t RegKfb    = 3'd3;
  localparam cfg_idx_t RegTarget = 3'd4;
  localparam cfg_idx_t RegMaxVel = 3'd5;
  localparam cfg_idx_t RegAngMin = 3'd6;
  localparam cfg_idx_t RegAngMax = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_POST = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    OP_EDT = 3'd0,
    OP_INT = 3'd1,
    OP_KP  = 3'd2,
    OP_FB  = 3'd3,
    OP_KD  = 3'd4,
    OP_VDT = 3'd5
  } op_t;

endpackage

// ===== rtl/pid_lqr_motor_angle_step_core.sv =====
// Top level of the PID plus state-feedback motor angle step controller.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | goal_angle, time_step
//  out_    | output    | out_valid/out_stall| velocity, angle, velocity_limited, angle_limited
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An item passes through an accept state, six products on the 16-step shift-add multiplier
// (each followed by a post state) and a result state that loads the output register.
// The 33-step restoring divider for the derivative runs alongside the first products.
// Reset is synchronous; control and kept state take their reset values at once, no clearing pass.
// A stalled result waits in the output register while the next item is computed;
// the block only holds in the result cycle if the previous result is still untaken.
`include "pid_lqr_motor_angle_step_core_defines.svh"

module pid_lqr_motor_angle_step_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [pidlqr_pkg::DataW-1:0]          in_goal_angle,
  input  logic [pidlqr_pkg::DataW-1:0]          in_time_step,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [pidlqr_pkg::VelW-1:0]    out_velocity,
  output logic [pidlqr_pkg::DataW-1:0]          out_angle,
  output logic                                  out_velocity_limited,
  output logic                                  out_angle_limited,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  pidlqr_pkg::cfg_idx_t                  cfg_index,
  input  logic [pidlqr_pkg::DataW-1:0]          cfg_data
);

  // Configuration registers
  logic [pidlqr_pkg::DataW-1:0] kp_r, kp_nxt, ki_r, ki_nxt, kd_r, kd_nxt, kfb_r, kfb_nxt;
  logic [pidlqr_pkg::DataW-1:0] target_r, target_nxt, max_vel_r, max_vel_nxt;
  logic [pidlqr_pkg::DataW-1:0] ang_min_r, ang_min_nxt, ang_max_r, ang_max_nxt;

  // Kept state
  logic [pidlqr_pkg::DataW-1:0]         angle_now_r, angle_now_nxt;
  logic signed [pidlqr_pkg::SumW-1:0]   es_r, es_nxt;
  logic signed [pidlqr_pkg::VelW-1:0]   prev_err_r, prev_err_nxt;

  // Sequencer
  pidlqr_pkg::state_t state_r, state_nxt;
  pidlqr_pkg::op_t    op_r, op_nxt;

  // Per-item operands
  logic [pidlqr_pkg::DataW-1:0]         dt_r, dt_nxt, tgt_r, tgt_nxt;
  logic signed [pidlqr_pkg::VelW-1:0]   e_r, e_nxt;
  logic signed [pidlqr_pkg::IntW-1:0]   ui_r, ui_nxt;
  logic signed [pidlqr_pkg::VelW-1:0]   vel_r, vel_nxt;
  logic                                 vlim_r, vlim_nxt, alim_r, alim_nxt;

  // Shift-add multiplier
  logic signed [pidlqr_pkg::AccW-1:0]   mcand_r, mcand_nxt, acc_r, acc_nxt;
  logic [pidlqr_pkg::DataW-1:0]         mplier_r, mplier_nxt;
  logic [pidlqr_pkg::MulCntW-1:0]       mcnt_r, mcnt_nxt;

  // Restoring divider
  logic [pidlqr_pkg::DivW-1:0]          div_q_r, div_q_nxt;
  logic [pidlqr_pkg::DataW-1:0]         div_rem_r, div_rem_nxt;
  logic [pidlqr_pkg::DivCntW-1:0]       div_cnt_r, div_cnt_nxt;
  logic                                 div_busy_r, div_busy_nxt, div_neg_r, div_neg_nxt;

  // Output register
  logic                                 out_valid_r, out_valid_nxt;
  logic signed [pidlqr_pkg::VelW-1:0]   out_vel_r, out_vel_nxt;
  logic [pidlqr_pkg::DataW-1:0]         out_angle_r, out_angle_nxt;
  logic                                 out_vlim_r, out_vlim_nxt, out_alim_r, out_alim_nxt;

  // Datapath helpers
  logic signed [pidlqr_pkg::VelW-1:0]   e_now, s_val;
  logic signed [pidlqr_pkg::VelW:0]     diff;
  logic [pidlqr_pkg::VelW-1:0]          diff_mag;
  logic [pidlqr_pkg::DataW-1:0]         dt_in;
  logic signed [pidlqr_pkg::SumW:0]     sum_ext;
  logic signed [pidlqr_pkg::SumW-1:0]   sat_sum;
  logic [pidlqr_pkg::DataW:0]           div_shift, div_sub;
  logic                                 div_ge;
  logic signed [pidlqr_pkg::DivW:0]     q_ext, d_val;
  logic signed [pidlqr_pkg::UW-1:0]     u_c, maxv_c;
  logic signed [pidlqr_pkg::VelW-1:0]   vel_c;
  logic                                 vlim_c;
  logic signed [34:0]                   rnd_c;
  logic signed [18:0]                   step_c;
  logic signed [19:0]                   pos_raw, pos_lo, pos_c, amin_ext, amax_ext;
  logic                                 alim_c;

  assign in_stall  = (state_r != pidlqr_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid            = out_valid_r;
  assign out_velocity         = out_vel_r;
  assign out_angle            = out_angle_r;
  assign out_velocity_limited = out_vlim_r;
  assign out_angle_limited    = out_alim_r;

  // Error terms and the divider's dividend magnitude
  always_comb begin
    e_now    = $signed({1'b0, target_r}) - $signed({1'b0, angle_now_r});
    s_val    = $signed({1'b0, tgt_r}) - $signed({1'b0, angle_now_r});
    diff     = $signed({e_now[pidlqr_pkg::VelW-1], e_now})
             - $signed({prev_err_r[pidlqr_pkg::VelW-1], prev_err_r});
    diff_mag = diff[pidlqr_pkg::VelW] ? pidlqr_pkg::VelW'(-diff) : diff[pidlqr_pkg::VelW-1:0];
    dt_in    = (in_time_step < pidlqr_pkg::MinDt) ? pidlqr_pkg::MinDt : in_time_step;
  end

  // Saturating integral update
  always_comb begin
    sum_ext = $signed({es_r[pidlqr_pkg::SumW-1], es_r}) + $signed(acc_r[pidlqr_pkg::SumW:0]);
    if (sum_ext[pidlqr_pkg::SumW] != sum_ext[pidlqr_pkg::SumW-1]) begin
      sat_sum = sum_ext[pidlqr_pkg::SumW] ? pidlqr_pkg::SumMin : pidlqr_pkg::SumMax;
    end else begin
      sat_sum = sum_ext[pidlqr_pkg::SumW-1:0];
    end
  end

  // One divider step and the signed quotient
  always_comb begin
    div_shift = {div_rem_r, div_q_r[pidlqr_pkg::DivW-1]};
    div_ge    = (div_shift >= {1'b0, dt_r});
    div_sub   = div_shift - {1'b0, dt_r};
    q_ext     = $signed({1'b0, div_q_r});
    d_val     = div_neg_r ? -q_ext : q_ext;
  end

  // Control sum and velocity clamp
  always_comb begin
    u_c    = pidlqr_pkg::UW'($signed(acc_r[52:14])) + pidlqr_pkg::UW'(ui_r);
    maxv_c = $signed({{(pidlqr_pkg::UW-pidlqr_pkg::DataW){1'b0}}, max_vel_r});
    vlim_c = 1'b1;
    if (u_c > maxv_c) begin
      vel_c = $signed({1'b0, max_vel_r});
    end else if (u_c < -maxv_c) begin
      vel_c = -$signed({1'b0, max_vel_r});
    end else begin
      vel_c  = u_c[pidlqr_pkg::VelW-1:0];
      vlim_c = 1'b0;
    end
  end

  // Rounded angle step and limit clamp; the upper limit wins when limits cross
  always_comb begin
    rnd_c    = $signed(acc_r[34:0]) + pidlqr_pkg::StepRound;
    step_c   = rnd_c[34:16];
    pos_raw  = $signed({4'b0, angle_now_r}) + 20'(step_c);
    amin_ext = $signed({4'b0, ang_min_r});
    amax_ext = $signed({4'b0, ang_max_r});
    pos_lo   = (pos_raw < amin_ext) ? amin_ext : pos_raw;
    pos_c    = (pos_lo > amax_ext) ? amax_ext : pos_lo;
    alim_c   = (pos_raw < amin_ext) || (pos_lo > amax_ext);
  end

  // Next-state logic
  always_comb begin
    kp_nxt        = kp_r;
    ki_nxt        = ki_r;
    kd_nxt        = kd_r;
    kfb_nxt       = kfb_r;
    target_nxt    = target_r;
    max_vel_nxt   = max_vel_r;
    ang_min_nxt   = ang_min_r;
    ang_max_nxt   = ang_max_r;
    angle_now_nxt = angle_now_r;
    es_nxt        = es_r;
    prev_err_nxt  = prev_err_r;
    state_nxt     = state_r;
    op_nxt        = op_r;
    dt_nxt        = dt_r;
    tgt_nxt       = tgt_r;
    e_nxt         = e_r;
    ui_nxt        = ui_r;
    vel_nxt       = vel_r;
    vlim_nxt      = vlim_r;
    alim_nxt      = alim_r;
    mcand_nxt     = mcand_r;
    acc_nxt       = acc_r;
    mplier_nxt    = mplier_r;
    mcnt_nxt      = mcnt_r;
    div_q_nxt     = div_q_r;
    div_rem_nxt   = div_rem_r;
    div_cnt_nxt   = div_cnt_r;
    div_busy_nxt  = div_busy_r;
    div_neg_nxt   = div_neg_r;
    out_valid_nxt = out_valid_r;
    out_vel_nxt   = out_vel_r;
    out_angle_nxt = out_angle_r;
    out_vlim_nxt  = out_vlim_r;
    out_alim_nxt  = out_alim_r;

    // Write a configuration register
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pidlqr_pkg::RegKp:     kp_nxt      = cfg_data;
        pidlqr_pkg::RegKi:     ki_nxt      = cfg_data;
        pidlqr_pkg::RegKd:     kd_nxt      = cfg_data;
        pidlqr_pkg::RegKfb:    kfb_nxt     = cfg_data;
        pidlqr_pkg::RegTarget: target_nxt  = cfg_data;
        pidlqr_pkg::RegMaxVel: max_vel_nxt = cfg_data;
        pidlqr_pkg::RegAngMin: ang_min_nxt = cfg_data;
        pidlqr_pkg::RegAngMax: ang_max_nxt = cfg_data;
        default: ;
      endcase
    end

    // Drop the result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // Advance the divider one quotient bit
    if (div_busy_r) begin
      div_rem_nxt = div_ge ? div_sub[pidlqr_pkg::DataW-1:0]
                           : div_shift[pidlqr_pkg::DataW-1:0];
      div_q_nxt   = {div_q_r[pidlqr_pkg::DivW-2:0], div_ge};
      div_cnt_nxt = div_cnt_r + 1'b1;
      if (div_cnt_r == pidlqr_pkg::DivCntW'(pidlqr_pkg::DivW - 1)) begin
        div_busy_nxt = 1'b0;
      end
    end

    case (state_r)
      pidlqr_pkg::ST_IDLE: begin
        // Take an item, start e*dt and the derivative division
        if (in_valid) begin
          dt_nxt       = dt_in;
          tgt_nxt      = in_goal_angle;
          e_nxt        = e_now;
          div_q_nxt    = {diff_mag, {pidlqr_pkg::DataW{1'b0}}};
          div_rem_nxt  = '0;
          div_cnt_nxt  = '0;
          div_busy_nxt = 1'b1;
          div_neg_nxt  = diff[pidlqr_pkg::VelW];
          mcand_nxt    = pidlqr_pkg::AccW'(e_now);
          mplier_nxt   = dt_in;
          acc_nxt      = '0;
          mcnt_nxt     = '0;
          op_nxt       = pidlqr_pkg::OP_EDT;
          state_nxt    = pidlqr_pkg::ST_MUL;
        end
      end
      pidlqr_pkg::ST_MUL: begin
        // One multiplier bit per cycle
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = mcand_r <<< 1;
        mplier_nxt = mplier_r >> 1;
        mcnt_nxt   = mcnt_r + 1'b1;
        if (mcnt_r == pidlqr_pkg::MulCntW'(pidlqr_pkg::MulSteps - 1)) begin
          state_nxt = pidlqr_pkg::ST_POST;
        end
      end
      pidlqr_pkg::ST_POST: begin
        // Finish the product just formed and load the next one, or after the last go to the result state
        case (op_r)
          pidlqr_pkg::OP_EDT: begin
            es_nxt     = sat_sum;
            mcand_nxt  = pidlqr_pkg::AccW'(sat_sum);
            mplier_nxt = ki_r;
            acc_nxt    = '0;
            op_nxt     = pidlqr_pkg::OP_INT;
            state_nxt  = pidlqr_pkg::ST_MUL;
          end
          pidlqr_pkg::OP_INT: begin
            ui_nxt     = acc_r[pidlqr_pkg::AccW-1:30];
            mcand_nxt  = pidlqr_pkg::AccW'(e_r);
            mplier_nxt = kp_r;
            acc_nxt    = '0;
            op_nxt     = pidlqr_pkg::OP_KP;
            state_nxt  = pidlqr_pkg::ST_MUL;
          end
          pidlqr_pkg::OP_KP: begin
            mcand_nxt  = pidlqr_pkg::AccW'(s_val);
            mplier_nxt = kfb_r;
            op_nxt     = pidlqr_pkg::OP_FB;
            state_nxt  = pidlqr_pkg::ST_MUL;
          end
          pidlqr_pkg::OP_FB: begin
            // Hold until the quotient is ready
            if (!div_busy_r) begin
              mcand_nxt  = pidlqr_pkg::AccW'(d_val);
              mplier_nxt = kd_r;
              op_nxt     = pidlqr_pkg::OP_KD;
              state_nxt  = pidlqr_pkg::ST_MUL;
            end
          end
          pidlqr_pkg::OP_KD: begin
            vel_nxt    = vel_c;
            vlim_nxt   = vlim_c;
            mcand_nxt  = pidlqr_pkg::AccW'(vel_c);
            mplier_nxt = dt_r;
            acc_nxt    = '0;
            op_nxt     = pidlqr_pkg::OP_VDT;
            state_nxt  = pidlqr_pkg::ST_MUL;
          end
          pidlqr_pkg::OP_VDT: begin
            angle_now_nxt = pos_c[pidlqr_pkg::DataW-1:0];
            alim_nxt      = alim_c;
            prev_err_nxt  = e_r;
            state_nxt     = pidlqr_pkg::ST_OUT;
          end
          default: begin
            state_nxt = pidlqr_pkg::ST_IDLE;
          end
        endcase
      end
      pidlqr_pkg::ST_OUT: begin
        // Load the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_vel_nxt   = vel_r;
          out_angle_nxt = angle_now_r;
          out_vlim_nxt  = vlim_r;
          out_alim_nxt  = alim_r;
          state_nxt     = pidlqr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pidlqr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and kept state, with synchronous reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= pidlqr_pkg::KpRst;
      ki_r        <= pidlqr_pkg::KiRst;
      kd_r        <= pidlqr_pkg::KdRst;
      kfb_r       <= pidlqr_pkg::KfbRst;
      target_r    <= pidlqr_pkg::TargetRst;
      max_vel_r   <= pidlqr_pkg::MaxVelRst;
      ang_min_r   <= pidlqr_pkg::AngMinRst;
      ang_max_r   <= pidlqr_pkg::AngMaxRst;
      angle_now_r <= pidlqr_pkg::AngleRst;
      es_r        <= '0;
      prev_err_r  <= '0;
      state_r     <= pidlqr_pkg::ST_IDLE;
      op_r        <= pidlqr_pkg::OP_EDT;
      mcnt_r      <= '0;
      div_cnt_r   <= '0;
      div_busy_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      kp_r        <= kp_nxt;
      ki_r        <= ki_nxt;
      kd_r        <= kd_nxt;
      kfb_r       <= kfb_nxt;
      target_r    <= target_nxt;
      max_vel_r   <= max_vel_nxt;
      ang_min_r   <= ang_min_nxt;
      ang_max_r   <= ang_max_nxt;
      angle_now_r <= angle_now_nxt;
      es_r        <= es_nxt;
      prev_err_r  <= prev_err_nxt;
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      mcnt_r      <= mcnt_nxt;
      div_cnt_r   <= div_cnt_nxt;
      div_busy_r  <= div_busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    dt_r        <= dt_nxt;
    tgt_r       <= tgt_nxt;
    e_r         <= e_nxt;
    ui_r        <= ui_nxt;
    vel_r       <= vel_nxt;
    vlim_r      <= vlim_nxt;
    alim_r      <= alim_nxt;
    mcand_r     <= mcand_nxt;
    acc_r       <= acc_nxt;
    mplier_r    <= mplier_nxt;
    div_q_r     <= div_q_nxt;
    div_rem_r   <= div_rem_nxt;
    div_neg_r   <= div_neg_nxt;
    out_vel_r   <= out_vel_nxt;
    out_angle_r <= out_angle_nxt;
    out_vlim_r  <= out_vlim_nxt;
    out_alim_r  <= out_alim_nxt;
  end

  // Derivative product starts only on a finished quotient
  `PLQ_ASSERT_IMP(a_kd_after_div, state_r == pidlqr_pkg::ST_MUL && op_r == pidlqr_pkg::OP_KD, !div_busy_r)
  // Result cycle loads the output register and returns to idle
  `PLQ_ASSERT_NXT(a_out_load, state_r == pidlqr_pkg::ST_OUT && (!out_valid_r || !out_stall), out_valid_r && state_r == pidlqr_pkg::ST_IDLE)
  // A limited velocity sits exactly on a bound
  `PLQ_ASSERT_IMP(a_vlim_bound, out_valid_r && out_vlim_r, out_vel_r == $signed({1'b0, max_vel_r}) || out_vel_r == -$signed({1'b0, max_vel_r}))
  // Divider never runs past its last quotient bit
  `PLQ_ASSERT_IMP(a_div_cnt, div_busy_r, div_cnt_r < pidlqr_pkg::DivCntW'(pidlqr_pkg::DivW))

endmodule
